FILE: design/hwf_pkg.sv
// Package with the types, constants and codes shared by the hue wheel fade RGB driver.
package hwf_pkg;

	localparam int ElapsedW = 17;
	localparam logic [ElapsedW-1:0] ELAPSED_MAX = 17'h1FFFF;
	localparam logic [8:0] HUE_MAX   = 9'd360;
	localparam logic [8:0] HUE_WRAP  = 9'd359;
	localparam logic [6:0] LEVEL_MAX = 7'd100;
	localparam logic [6:0] LEVEL_RST = 7'd100;
	localparam logic [7:0] FADE_SPAN = 8'd200;
	localparam logic [7:0] PHASE_TOP = 8'd199;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		REG_WHEEL_EN  = 3'd0,
		REG_FADE_EN   = 3'd1,
		REG_WHEEL_PER = 3'd2,
		REG_FADE_PER  = 3'd3,
		REG_FADE_FLR  = 3'd4,
		REG_INVERT    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		cmd_t       command;
		logic [8:0] hue_in;
		logic [6:0] level_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hue_now;
		logic [6:0] level_now;
	} out_item_t;

	typedef struct packed {
		logic        wheel_enable;
		logic        fade_enable;
		logic [15:0] wheel_period;
		logic [15:0] fade_period;
		logic [6:0]  fade_floor;
		logic        invert_output;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load_item;
		logic stage1;
		logic stage2;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

FILE: design/hwf_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module hwf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  hwf_pkg::dp_stat_t stat,
	output hwf_pkg::dp_cmd_t  cmd
);
	import hwf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.stage1 = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.stage2 = 1'b1;
				state_d    = ST_FINAL;
			end
			ST_FINAL: begin
				// Hold here until the result register can take the new result.
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/hwf_datapath.sv
// Datapath with the hue and fade state, the color scaling multipliers and the result register.
module hwf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hwf_pkg::cfg_t     cfg,
	input  hwf_pkg::in_item_t item,
	input  hwf_pkg::dp_cmd_t  cmd,
	output hwf_pkg::dp_stat_t stat,
	output logic              result_valid,
	input  logic              result_stall,
	output hwf_pkg::out_item_t result
);
	import hwf_pkg::*;

	logic [8:0]          hue_q;
	logic [6:0]          level_q;
	logic [ElapsedW-1:0] wheel_elapsed_q;
	logic [ElapsedW-1:0] fade_elapsed_q;
	logic [7:0]          fade_phase_q;

	logic [9:0]  hue_x_q;
	logic [10:0] lvl_x_q;
	logic [7:0]  h_q;
	logic [7:0]  b_q;
	logic        result_valid_q;
	out_item_t   result_q;

	// Tick update.
	logic [ElapsedW-1:0] wheel_inc, fade_inc;
	logic                wheel_step, fade_step;
	logic [9:0]          hue_plus;
	logic [8:0]          hue_wrap;
	logic [6:0]          lv_raw, lv;
	logic [7:0]          phase_c, phase_next;
	logic [6:0]          level_fade;
	logic [7:0]          span_diff;

	always_comb begin
		wheel_inc  = (wheel_elapsed_q < ELAPSED_MAX) ? wheel_elapsed_q + 1'b1 : wheel_elapsed_q;
		fade_inc   = (fade_elapsed_q < ELAPSED_MAX) ? fade_elapsed_q + 1'b1 : fade_elapsed_q;
		wheel_step = cfg.wheel_enable && (wheel_inc > {1'b0, cfg.wheel_period});
		fade_step  = cfg.fade_enable && (fade_inc > {1'b0, cfg.fade_period});

		hue_plus = {1'b0, hue_q} + 10'd1;
		hue_wrap = (hue_plus >= {1'b0, HUE_WRAP}) ? 9'(hue_plus - {1'b0, HUE_WRAP})
		                                           : hue_plus[8:0];

		// Triangle: rises 0..100 over the first half of the phase, falls after.
		span_diff = FADE_SPAN - fade_phase_q;
		lv_raw    = (fade_phase_q <= {1'b0, LEVEL_MAX}) ? fade_phase_q[6:0] : span_diff[6:0];
		if (lv_raw < cfg.fade_floor) begin
			lv      = cfg.fade_floor;
			phase_c = (cfg.fade_floor <= LEVEL_MAX) ? {1'b0, cfg.fade_floor}
			                                        : FADE_SPAN - {1'b0, cfg.fade_floor};
		end else begin
			lv      = lv_raw;
			phase_c = fade_phase_q;
		end
		level_fade = (lv <= LEVEL_MAX) ? lv : level_q;
		phase_next = (phase_c >= PHASE_TOP) ? 8'd0 : phase_c + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q           <= '0;
			level_q         <= LEVEL_RST;
			wheel_elapsed_q <= '0;
			fade_elapsed_q  <= '0;
			fade_phase_q    <= '0;
		end else if (cmd.load_item) begin
			if (item.command == CMD_SET) begin
				if (item.hue_in <= HUE_MAX) begin
					hue_q <= item.hue_in;
				end
				if (item.level_in <= LEVEL_MAX) begin
					level_q <= item.level_in;
				end
			end else begin
				wheel_elapsed_q <= wheel_step ? '0 : wheel_inc;
				fade_elapsed_q  <= fade_step ? '0 : fade_inc;
				if (wheel_step) begin
					hue_q <= hue_wrap;
				end
				if (fade_step) begin
					level_q      <= level_fade;
					fade_phase_q <= phase_next;
				end
			end
		end
	end

	// First scaling step: hue*17/8 and level*51/4.
	logic [12:0] hue_m17, lvl_m51;
	assign hue_m17 = {4'b0, hue_q} * 13'd17;
	assign lvl_m51 = {6'b0, level_q} * 13'd51;

	always_ff @(posedge clk) begin
		if (cmd.stage1) begin
			hue_x_q <= hue_m17[12:3];
			lvl_x_q <= lvl_m51[12:2];
		end
	end

	// Second step: divide by 3 and by 5 through reciprocal multiplies.
	logic [19:0] hue_div;
	logic [22:0] lvl_div;
	assign hue_div = {10'b0, hue_x_q} * 20'd683;
	assign lvl_div = {12'b0, lvl_x_q} * 23'd3277;

	always_ff @(posedge clk) begin
		if (cmd.stage2) begin
			h_q <= hue_div[18:11];
			b_q <= lvl_div[21:14];
		end
	end

	// Final step: segment, ramps, optional inversion.
	logic [10:0] scaled;
	logic [2:0]  seg;
	logic [7:0]  off, off_inv;
	logic [15:0] prev_m, next_m;
	logic [7:0]  bb, prev, next, comp;
	out_item_t   rgb;

	always_comb begin
		scaled  = {1'b0, h_q, 2'b0} + {2'b0, h_q, 1'b0};
		seg     = scaled[10:8];
		off     = scaled[7:0];
		off_inv = 8'hFF - off;
		prev_m  = {8'b0, b_q} * {8'b0, off_inv};
		next_m  = {8'b0, b_q} * {8'b0, off};
		bb      = cfg.invert_output ? ~b_q : b_q;
		prev    = cfg.invert_output ? ~prev_m[15:8] : prev_m[15:8];
		next    = cfg.invert_output ? ~next_m[15:8] : next_m[15:8];
		comp    = cfg.invert_output ? 8'hFF : 8'h00;

		rgb           = '0;
		rgb.hue_now   = hue_q;
		rgb.level_now = level_q;
		if (h_q == 8'hFF) begin
			// Hue 360 is white at the scaled level, never inverted.
			rgb.red   = b_q;
			rgb.green = b_q;
			rgb.blue  = b_q;
		end else begin
			case (seg)
				3'd0: begin rgb.red = bb;   rgb.green = next; rgb.blue = comp; end
				3'd1: begin rgb.red = prev; rgb.green = bb;   rgb.blue = comp; end
				3'd2: begin rgb.red = comp; rgb.green = bb;   rgb.blue = next; end
				3'd3: begin rgb.red = comp; rgb.green = prev; rgb.blue = bb;   end
				3'd4: begin rgb.red = next; rgb.green = comp; rgb.blue = bb;   end
				default: begin rgb.red = bb; rgb.green = comp; rgb.blue = prev; end
			endcase
		end
	end

	assign stat.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q <= rgb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: design/hue_wheel_fade_rgb_driver.sv
// Top level of the hue wheel fade RGB driver: configuration registers, controller and datapath.
//
// The block keeps a hue (0..360) and a level percent (0..100) and returns one RGB
// transaction for every input transaction. A set transaction writes hue and level,
// each only when in range; a tick transaction advances the saturating wheel and
// fade counters, steps the hue around the wheel and walks the triangle fade when a
// counter passes its period. Each input transaction runs through the controller
// states in order: IDLE accepts it and updates the state, MUL1 and MUL2 run the
// constant scaling multiplies that map hue to 0..255 and level to 0..255, and FINAL
// forms the ramps and loads the result register. The block accepts no new input
// transaction until the last one is in the result register, which lets the next
// input transaction be accepted while a finished result is still stalled; the
// block then holds that transaction's result until the register frees up.
// Configuration registers sit at byte addresses 0, 4, ... 20 on the APB port in
// the order wheel_enable, fade_enable, wheel_period, fade_period, fade_floor,
// invert_output, and should be written while no transaction is in flight.
module hue_wheel_fade_rgb_driver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  hwf_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output hwf_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import hwf_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	reg_idx_t reg_idx;

	// The register index comes from the word address; the byte offset is ignored.
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_enable  <= 1'b0;
			cfg_q.fade_enable   <= 1'b0;
			cfg_q.wheel_period  <= 16'd50;
			cfg_q.fade_period   <= 16'd50;
			cfg_q.fade_floor    <= 7'd10;
			cfg_q.invert_output <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WHEEL_EN:  cfg_q.wheel_enable  <= pwdata[0];
				REG_FADE_EN:   cfg_q.fade_enable   <= pwdata[0];
				REG_WHEEL_PER: cfg_q.wheel_period  <= pwdata[15:0];
				REG_FADE_PER:  cfg_q.fade_period   <= pwdata[15:0];
				REG_FADE_FLR:  cfg_q.fade_floor    <= pwdata[6:0];
				REG_INVERT:    cfg_q.invert_output <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read data is a plain decode of the register file.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_WHEEL_EN:  prdata = {31'b0, cfg_q.wheel_enable};
			REG_FADE_EN:   prdata = {31'b0, cfg_q.fade_enable};
			REG_WHEEL_PER: prdata = {16'b0, cfg_q.wheel_period};
			REG_FADE_PER:  prdata = {16'b0, cfg_q.fade_period};
			REG_FADE_FLR:  prdata = {25'b0, cfg_q.fade_floor};
			REG_INVERT:    prdata = {31'b0, cfg_q.invert_output};
			default:       prdata = '0;
		endcase
	end

	// The controller only sees the input handshake and the result register status.
	hwf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath takes the item straight off the port on the accept cycle.
	hwf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: design/hwf_checker.sv
// Port-level checker for the hue wheel fade RGB driver and its bind statement.
module hwf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input hwf_pkg::out_item_t result
);
	import hwf_pkg::*;

	// A stalled result stays valid and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// The block works on one transaction at a time after accepting it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted back to back");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.hue_now <= HUE_MAX && result.level_now <= LEVEL_MAX)
		else $error("reported hue or level out of range");

	// Hue 360 is white: all three channels equal.
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hue_now == HUE_MAX |->
			result.red == result.green && result.green == result.blue)
		else $error("hue 360 is not white");

endmodule

bind hue_wheel_fade_rgb_driver hwf_checker u_hwf_checker (.*);

FILE: verif/tb_hue_wheel_fade_rgb_driver.sv
// Self-checking testbench for the hue wheel fade RGB driver with its own color predictor.
module tb_hue_wheel_fade_rgb_driver;
	timeunit 1ns;
	timeprecision 1ps;

	import hwf_pkg::*;

	// Clock, reset and every input of the block start at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hue_wheel_fade_rgb_driver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Input transactions waiting to be driven, and the RGB results that the
	// predictor expects, oldest first.
	in_item_t  item_pending[$];
	out_item_t rgb_expected[$];
	int        mismatches = 0;

	// The predictor's copy of the configuration registers and of the block state.
	cfg_t          cfg_shadow;
	logic [8:0]    cur_hue;
	logic [6:0]    cur_level;
	logic [16:0]   wheel_ticks;
	logic [16:0]   fade_ticks;
	logic [7:0]    fade_pos;

	// Set when the previous rising edge accepted an input transaction.
	logic item_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one input transaction to the predicted state and returns the
	// RGB result that the block must produce for it.
	function automatic out_item_t predict_rgb(in_item_t it);
		int        h, b, scaled, seg, off, prev, next, comp, lv, delta;
		int        r, g, bl;
		out_item_t o;
		if (it.command == CMD_SET) begin
			// Hue and level are each taken only when in range.
			if (it.hue_in <= HUE_MAX)
				cur_hue = it.hue_in;
			if (it.level_in <= LEVEL_MAX)
				cur_level = it.level_in;
		end else begin
			// Both counters run even while their function is disabled and stop
			// at the top of their range.
			if (wheel_ticks != ELAPSED_MAX)
				wheel_ticks = wheel_ticks + 1'b1;
			if (fade_ticks != ELAPSED_MAX)
				fade_ticks = fade_ticks + 1'b1;
			if (cfg_shadow.wheel_enable && wheel_ticks > cfg_shadow.wheel_period) begin
				cur_hue = 9'((int'(cur_hue) + 1) % int'(HUE_WRAP));
				wheel_ticks = '0;
			end
			if (cfg_shadow.fade_enable && fade_ticks > cfg_shadow.fade_period) begin
				// Triangle over 200 phases, peak 100 at the middle.
				delta = int'(fade_pos) - 100;
				if (delta < 0)
					delta = -delta;
				lv = 100 - delta;
				if (lv < int'(cfg_shadow.fade_floor)) begin
					// Clamp at the floor and move the phase to match it; a floor
					// above 100 puts the phase at 200 minus the floor.
					lv = int'(cfg_shadow.fade_floor);
					delta = lv - 100;
					if (delta < 0)
						delta = -delta;
					fade_pos = 8'(100 - delta);
				end
				if (lv <= int'(LEVEL_MAX))
					cur_level = 7'(lv);
				fade_pos = 8'((int'(fade_pos) + 1) % int'(FADE_SPAN));
				fade_ticks = '0;
			end
		end

		h = int'(cur_hue) * 255 / 360;
		b = int'(cur_level) * 255 / 100;
		if (h == 255) begin
			// Hue 360 is white at the scaled level, never inverted.
			r = b;
			g = b;
			bl = b;
		end else begin
			scaled = h * 6;
			seg = scaled / 256;
			off = scaled % 256;
			prev = b * (255 - off) / 256;
			next = b * off / 256;
			comp = 0;
			if (cfg_shadow.invert_output) begin
				b = 255 - b;
				comp = 255;
				prev = 255 - prev;
				next = 255 - next;
			end
			case (seg)
				0: begin r = b; g = next; bl = comp; end
				1: begin r = prev; g = b; bl = comp; end
				2: begin r = comp; g = b; bl = next; end
				3: begin r = comp; g = prev; bl = b; end
				4: begin r = next; g = comp; bl = b; end
				default: begin r = b; g = comp; bl = prev; end
			endcase
		end
		o.red = 8'(r);
		o.green = 8'(g);
		o.blue = 8'(bl);
		o.hue_now = cur_hue;
		o.level_now = cur_level;
		return o;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	// Monitor: every accepted input transaction feeds the predictor, and every
	// accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		item_taken <= arst_n && item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall)
			rgb_expected.push_back(predict_rgb(item));
		if (arst_n && result_valid && !result_stall) begin
			if (rgb_expected.size() == 0) begin
				mismatches++;
				$error("result transaction with no expectation waiting");
			end else begin
				out_item_t want;
				want = rgb_expected.pop_front();
				check_field("red", want.red, result.red);
				check_field("green", want.green, result.green);
				check_field("blue", want.blue, result.blue);
				check_field("hue_now", want.hue_now, result.hue_now);
				check_field("level_now", want.level_now, result.level_now);
			end
		end
	end

	// Driver: sends pending transactions in bursts of random length, with
	// random gaps between bursts and now and then a long burst with no gap at
	// all. A transaction that has not been accepted is held unchanged.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left > 0 || item_pending.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				item_valid <= 1'b0;
			end else begin
				item <= item_pending.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(0, 15);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Result side stalls on its own pattern: stretches of no stall, light and
	// heavy random stall, and runs of long stalls, so that stalls fall on every
	// state of the controller's sequence.
	int rx_cycle = 0;
	int stall_hold = 0;

	always @(negedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 300) % 4)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					result_stall <= 1'b1;
				end else begin
					result_stall <= 1'b0;
					if ($urandom_range(0, 7) == 0)
						stall_hold = $urandom_range(1, 20);
				end
			end
		endcase
	end

	// One register write: setup cycle, access cycle, done at the edge where
	// pready is seen high. The predictor's copy follows the write.
	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WHEEL_EN: cfg_shadow.wheel_enable = value[0];
			REG_FADE_EN: cfg_shadow.fade_enable = value[0];
			REG_WHEEL_PER: cfg_shadow.wheel_period = value[15:0];
			REG_FADE_PER: cfg_shadow.fade_period = value[15:0];
			REG_FADE_FLR: cfg_shadow.fade_floor = value[6:0];
			default: cfg_shadow.invert_output = value[0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_regs(int wheel_en, int fade_en, int wheel_per, int fade_per,
			int floor_lvl, int inv);
		apb_write(REG_WHEEL_EN, 32'(wheel_en));
		apb_write(REG_FADE_EN, 32'(fade_en));
		apb_write(REG_WHEEL_PER, 32'(wheel_per));
		apb_write(REG_FADE_PER, 32'(fade_per));
		apb_write(REG_FADE_FLR, 32'(floor_lvl));
		apb_write(REG_INVERT, 32'(inv));
	endtask

	task automatic queue_item(cmd_t cmd, int hue_val, int level_val);
		in_item_t it;
		it.command = cmd;
		it.hue_in = 9'(hue_val);
		it.level_in = 7'(level_val);
		item_pending.push_back(it);
	endtask

	// Mostly in-range values; one time in five the whole field range, which
	// also exercises the ignore rules and toggles the top bits.
	task automatic queue_random(int count, int set_pct);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it.command = ($urandom_range(0, 99) < set_pct) ? CMD_SET : CMD_TICK;
			it.hue_in = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
				: 9'($urandom_range(0, 360));
			it.level_in = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(0, 100));
			item_pending.push_back(it);
		end
	endtask

	// Waits until every queued transaction was sent and every result came
	// back, then lets the block settle before registers change.
	task automatic wait_idle();
		do @(negedge clk);
		while (item_pending.size() != 0 || item_valid || rgb_expected.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// Period picker: mostly short periods so the wheel and fade step often.
	function automatic int pick_period();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(8, 40);
			default: return $urandom_range(0, 5);
		endcase
	endfunction

	initial begin
		cfg_shadow.wheel_enable = 1'b0;
		cfg_shadow.fade_enable = 1'b0;
		cfg_shadow.wheel_period = 16'd50;
		cfg_shadow.fade_period = 16'd50;
		cfg_shadow.fade_floor = 7'd10;
		cfg_shadow.invert_output = 1'b0;
		cur_hue = '0;
		cur_level = LEVEL_RST;
		wheel_ticks = '0;
		fade_ticks = '0;
		fade_pos = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset configuration: the six color segments,
		// white at full and zero level, out-of-range hue and level each alone
		// and together, and a tick that must not step anything while disabled.
		queue_item(CMD_SET, 0, 100);
		queue_item(CMD_SET, 60, 100);
		queue_item(CMD_SET, 120, 100);
		queue_item(CMD_SET, 180, 100);
		queue_item(CMD_SET, 240, 100);
		queue_item(CMD_SET, 300, 100);
		queue_item(CMD_SET, 359, 100);
		queue_item(CMD_SET, 360, 100);
		queue_item(CMD_SET, 360, 0);
		queue_item(CMD_SET, 361, 55);
		queue_item(CMD_SET, 200, 101);
		queue_item(CMD_SET, 511, 127);
		queue_item(CMD_SET, 0, 0);
		queue_item(CMD_TICK, 511, 127);
		wait_idle();

		// Both steppers on every tick, with inverted output. The wheel steps
		// from 360 to 2, the fade starts below the floor and is clamped, set
		// transactions in between must not advance the counters, and white
		// ignores the invert.
		program_regs(1, 1, 0, 0, 10, 1);
		queue_item(CMD_SET, 360, 100);
		queue_item(CMD_TICK, 0, 0);
		queue_item(CMD_SET, 100, 100);
		queue_item(CMD_TICK, 0, 0);
		queue_item(CMD_SET, 30, 60);
		queue_item(CMD_TICK, 0, 0);
		queue_item(CMD_SET, 360, 80);
		queue_item(CMD_SET, 0, 0);
		queue_item(CMD_TICK, 0, 0);
		wait_idle();

		// Random phases over fixed corners of the configuration space,
		// including floor zero, floor 100 and floors above 100.
		program_regs(1, 1, 0, 0, 0, 0);
		queue_random(150, 20);
		wait_idle();
		program_regs(1, 0, 3, 65535, 50, 1);
		queue_random(150, 30);
		wait_idle();
		program_regs(0, 1, 65535, 2, 100, 0);
		queue_random(150, 20);
		wait_idle();
		program_regs(1, 1, 1, 0, 127, 1);
		queue_random(150, 15);
		wait_idle();
		program_regs(1, 1, 0, 1, 101, 0);
		queue_random(100, 15);
		wait_idle();

		// Random phases over random configurations.
		for (int p = 0; p < 4; p++) begin
			program_regs($urandom_range(0, 1), $urandom_range(0, 1), pick_period(),
				pick_period(), $urandom_range(0, 127), $urandom_range(0, 1));
			queue_random(130, 25);
			wait_idle();
		end

		// Counters keep running while both steppers are off, so the first
		// tick after the enables steps the wheel and the fade at once.
		program_regs(0, 0, 4, 4, 0, 0);
		for (int i = 0; i < 8; i++)
			queue_item(CMD_TICK, $urandom_range(0, 511), $urandom_range(0, 127));
		wait_idle();
		apb_write(REG_WHEEL_EN, 32'd1);
		apb_write(REG_FADE_EN, 32'd1);
		queue_item(CMD_TICK, 0, 0);
		queue_item(CMD_TICK, 0, 0);
		queue_item(CMD_SET, 360, 100);
		wait_idle();

		repeat (16) @(posedge clk);
		if (rgb_expected.size() != 0) begin
			mismatches++;
			$error("%0d expected result transactions never arrived", rgb_expected.size());
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Safety net well beyond the slowest legal run.
	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

endmodule
